// ===== src/mmed_pkg.sv =====
// shared constants, types and register codes for the min/max envelope decimator
`timescale 1ns / 1ps

package mmed_pkg;

   // default build configuration
   localparam int MAX_CHANNELS_DEF = 8;
   localparam int SAMPLE_BITS_DEF  = 17;

   // number of sample fields carried by one request
   localparam int FIELD_CHANNELS = 8;

   // result and register widths
   localparam int OUT_BITS        = 17;
   localparam int CC_BITS         = 4;
   localparam int FPB_BITS        = 16;
   localparam int CSR_INDEX_BITS  = 1;
   localparam int CSR_DATA_BITS   = 16;

   // configuration register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CHANNEL_COUNT     = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAMES_PER_BUCKET = 1'd1;

   // register reset values
   localparam logic [CC_BITS-1:0]  CC_RESET  = 4'd2;
   localparam logic [FPB_BITS-1:0] FPB_RESET = 16'd1;

   // full-scale limits in Q.15
   localparam int UNIT_POS = 32768;
   localparam int UNIT_NEG = -32768;

   // control that travels down the pipeline next to each request
   typedef struct packed {
      logic valid;
      logic last;
   } stage_ctl_type;

endpackage

// ===== src/mmed_if.sv =====
// request and result channel interfaces
`timescale 1ns / 1ps

interface mmed_req_if #(
   parameter int SAMPLE_BITS = mmed_pkg::SAMPLE_BITS_DEF
);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample_0;
   logic signed [SAMPLE_BITS-1:0] sample_1;
   logic signed [SAMPLE_BITS-1:0] sample_2;
   logic signed [SAMPLE_BITS-1:0] sample_3;
   logic signed [SAMPLE_BITS-1:0] sample_4;
   logic signed [SAMPLE_BITS-1:0] sample_5;
   logic signed [SAMPLE_BITS-1:0] sample_6;
   logic signed [SAMPLE_BITS-1:0] sample_7;
   logic                          final_frame;

   modport source (
      output valid, sample_0, sample_1, sample_2, sample_3,
             sample_4, sample_5, sample_6, sample_7, final_frame,
      input  ready
   );
   modport sink (
      input  valid, sample_0, sample_1, sample_2, sample_3,
             sample_4, sample_5, sample_6, sample_7, final_frame,
      output ready
   );
endinterface

interface mmed_rsp_if;
   logic                                    valid;
   logic                                    ready;
   logic signed [mmed_pkg::OUT_BITS-1:0]    bucket_min;
   logic signed [mmed_pkg::OUT_BITS-1:0]    bucket_max;
   logic                                    clip_end;

   modport source (
      output valid, bucket_min, bucket_max, clip_end,
      input  ready
   );
   modport sink (
      input  valid, bucket_min, bucket_max, clip_end,
      output ready
   );
endinterface

// ===== src/mmed_lane.sv =====
// one channel lane: drops inactive channels and registers the sample
`timescale 1ns / 1ps

module mmed_lane #(
   parameter int SAMPLE_BITS = 17,
   parameter int NW          = 4,
   parameter int LANE_IDX    = 0
) (
   input  logic                          clock,
   input  logic                          adv,
   input  logic [NW-1:0]                 n_eff,
   input  logic signed [SAMPLE_BITS-1:0] sample,
   output logic signed [SAMPLE_BITS-1:0] lane_out
);
   logic signed [SAMPLE_BITS-1:0] lane_ff;
   logic signed [SAMPLE_BITS-1:0] lane_in;
   logic                          active;

   // channel takes part only below the active channel count
   assign active  = NW'(LANE_IDX) < n_eff;
   assign lane_in = active ? sample : '0;

   always_ff @(posedge clock) begin
      if (adv) begin
         lane_ff <= lane_in;
      end
   end

   assign lane_out = lane_ff;
endmodule

// ===== src/mmed_merge.sv =====
// merging stage: sums the lane values of one frame
`timescale 1ns / 1ps

module mmed_merge #(
   parameter int MAX_CHANNELS = 8,
   parameter int SAMPLE_BITS  = 17,
   parameter int SW           = 21
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          adv,
   input  mmed_pkg::stage_ctl_type       ctl_i,
   input  logic signed [SAMPLE_BITS-1:0] lane_val [MAX_CHANNELS],
   output mmed_pkg::stage_ctl_type       ctl_o,
   output logic signed [SW-1:0]          sum_o
);
   import mmed_pkg::*;

   stage_ctl_type         ctl_ff;
   logic signed [SW-1:0]  sum_ff;
   logic signed [SW-1:0]  sum_in;

   // add the sign-extended lanes
   always_comb begin
      sum_in = '0;
      for (int i = 0; i < MAX_CHANNELS; i++) begin
         sum_in = sum_in + SW'(lane_val[i]);
      end
   end

   // control moves with the pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (adv) begin
         ctl_ff <= ctl_i;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sum_ff <= sum_in;
      end
   end

   assign ctl_o = ctl_ff;
   assign sum_o = sum_ff;
endmodule

// ===== src/mmed_divide.sv =====
// divides the frame sum by the channel count, truncating toward zero
`timescale 1ns / 1ps

module mmed_divide #(
   parameter int MAX_CHANNELS = 8,
   parameter int SW           = 21,
   parameter int NW           = 4
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     adv,
   input  mmed_pkg::stage_ctl_type  ctl_i,
   input  logic signed [SW-1:0]     sum_i,
   input  logic [NW-1:0]            n_eff,
   output mmed_pkg::stage_ctl_type  ctl_o,
   output logic signed [SW-1:0]     avg_o
);
   import mmed_pkg::*;

   // reciprocal scale: the magnitude stays below 2**K
   localparam int K   = SW;
   localparam int RW  = K + 1;
   localparam int PW  = SW + RW;
   localparam int QW  = SW + NW;
   localparam int TAB = 2 ** NW;

   logic [RW-1:0] recip_tab [TAB];

   // reciprocal table floor(2**K / n), unused codes read zero
   for (genvar g = 0; g < TAB; g++) begin : g_recip
      localparam logic [RW-1:0] RV =
         (g == 0 || g > MAX_CHANNELS) ? '0 :
         RW'((64'd1 << K) / (g + ((g == 0) ? 1 : 0)));
      assign recip_tab[g] = RV;
   end

   stage_ctl_type        ctl_a_ff;
   stage_ctl_type        ctl_b_ff;
   logic [PW-1:0]        prod_ff;
   logic [PW-1:0]        prod_in;
   logic [SW-1:0]        mag_ff;
   logic [SW-1:0]        mag_in;
   logic                 neg_ff;
   logic                 neg_in;
   logic signed [SW-1:0] avg_ff;
   logic signed [SW-1:0] avg_in;
   logic [SW-1:0]        q_est;
   logic [QW-1:0]        q_times_n;
   logic [QW-1:0]        rem;
   logic                 bump;
   logic [SW-1:0]        q_fix;

   // first step: magnitude times reciprocal
   assign neg_in  = sum_i[SW-1];
   assign mag_in  = neg_in ? SW'(-sum_i) : SW'(sum_i);
   assign prod_in = PW'(mag_in) * PW'(recip_tab[n_eff]);

   // second step: the estimate is exact or one short
   assign q_est     = prod_ff[K +: SW];
   assign q_times_n = QW'(q_est) * QW'(n_eff);
   assign rem       = QW'(mag_ff) - q_times_n;
   assign bump      = rem >= QW'(n_eff);
   assign q_fix     = q_est + SW'(bump);
   assign avg_in    = neg_ff ? -$signed(q_fix) : $signed(q_fix);

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_a_ff <= '0;
         ctl_b_ff <= '0;
      end else if (adv) begin
         ctl_a_ff <= ctl_i;
         ctl_b_ff <= ctl_a_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         prod_ff <= prod_in;
         mag_ff  <= mag_in;
         neg_ff  <= neg_in;
         avg_ff  <= avg_in;
      end
   end

   assign ctl_o = ctl_b_ff;
   assign avg_o = avg_ff;
endmodule

// ===== src/minmax_envelope_decimator.sv =====
// top level: lanes, merge, divider, bucket min/max tracking and result register
// path: an accepted request passes the lane, merge and divider registers, then the result register
// throughput: one frame per cycle while the pipeline does not hold; lane, merge and divider registers move as one
// the pipeline holds only while a frame that closes a bucket meets a full result register
// reset: synchronous, clears valid bits and bucket count, sets min/max to +1.0/-1.0
// and loads the two configuration registers with their defaults
`timescale 1ns / 1ps

module minmax_envelope_decimator #(
   parameter int MAX_CHANNELS = mmed_pkg::MAX_CHANNELS_DEF,
   parameter int SAMPLE_BITS  = mmed_pkg::SAMPLE_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   mmed_req_if.sink                              req_chan,
   mmed_rsp_if.source                            rsp_chan,
   input  logic                                  csr_we,
   input  logic [mmed_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [mmed_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);
   import mmed_pkg::*;

   localparam int NW = $clog2(MAX_CHANNELS + 1);
   localparam int SW = SAMPLE_BITS + NW;
   localparam int MW = (SW > OUT_BITS) ? SW : OUT_BITS;
   localparam logic signed [MW-1:0] POS_W = MW'(UNIT_POS);
   localparam logic signed [MW-1:0] NEG_W = MW'(UNIT_NEG);

   logic [CC_BITS-1:0]   cc_ff;
   logic [FPB_BITS-1:0]  fpb_ff;
   logic [NW-1:0]        n_eff;
   logic [FPB_BITS-1:0]  limit;

   stage_ctl_type        ctl0_ff;
   stage_ctl_type        ctl0_in;
   stage_ctl_type        ctl1;
   stage_ctl_type        ctl3;
   logic                 adv;

   logic signed [SAMPLE_BITS-1:0] sample_arr [FIELD_CHANNELS];
   logic signed [SAMPLE_BITS-1:0] lane_val   [MAX_CHANNELS];
   logic signed [SW-1:0]          sum;
   logic signed [SW-1:0]          avg;

   logic [FPB_BITS-1:0]  count_ff;
   logic [FPB_BITS-1:0]  count_in;
   logic signed [MW-1:0] min_ff;
   logic signed [MW-1:0] min_in;
   logic signed [MW-1:0] max_ff;
   logic signed [MW-1:0] max_in;
   logic signed [MW-1:0] avg_w;
   logic signed [MW-1:0] min_clamp;
   logic signed [MW-1:0] max_clamp;
   logic                 emit;
   logic                 take;

   logic                       rsp_valid_ff;
   logic signed [OUT_BITS-1:0] rsp_min_ff;
   logic signed [OUT_BITS-1:0] rsp_max_ff;
   logic                       rsp_end_ff;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cc_ff  <= CC_RESET;
         fpb_ff <= FPB_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_CHANNEL_COUNT:     cc_ff  <= csr_wdata[CC_BITS-1:0];
            CSR_FRAMES_PER_BUCKET: fpb_ff <= csr_wdata[FPB_BITS-1:0];
            default:               ;
         endcase
      end
   end

   // effective channel count and bucket size
   always_comb begin
      priority if (cc_ff == '0) begin
         n_eff = NW'(1);
      end else if (32'(cc_ff) > MAX_CHANNELS) begin
         n_eff = NW'(MAX_CHANNELS);
      end else begin
         n_eff = NW'(cc_ff);
      end
   end
   assign limit = (fpb_ff == '0) ? FPB_BITS'(1) : fpb_ff;

   // pipeline holds only when a closing frame finds the result register full
   assign adv          = !(ctl3.valid && emit && rsp_valid_ff && !rsp_chan.ready);
   assign req_chan.ready = adv;
   assign take         = adv && ctl3.valid;

   // request fields into a lane array
   assign sample_arr[0] = req_chan.sample_0;
   assign sample_arr[1] = req_chan.sample_1;
   assign sample_arr[2] = req_chan.sample_2;
   assign sample_arr[3] = req_chan.sample_3;
   assign sample_arr[4] = req_chan.sample_4;
   assign sample_arr[5] = req_chan.sample_5;
   assign sample_arr[6] = req_chan.sample_6;
   assign sample_arr[7] = req_chan.sample_7;

   for (genvar g = 0; g < MAX_CHANNELS; g++) begin : g_lane
      mmed_lane #(
         .SAMPLE_BITS (SAMPLE_BITS),
         .NW          (NW),
         .LANE_IDX    (g)
      ) u_lane (
         .clock    (clock),
         .adv      (adv),
         .n_eff    (n_eff),
         .sample   (sample_arr[g]),
         .lane_out (lane_val[g])
      );
   end

   // control for the lane stage
   assign ctl0_in.valid = req_chan.valid;
   assign ctl0_in.last  = req_chan.final_frame;

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl0_ff <= '0;
      end else if (adv) begin
         ctl0_ff <= ctl0_in;
      end
   end

   mmed_merge #(
      .MAX_CHANNELS (MAX_CHANNELS),
      .SAMPLE_BITS  (SAMPLE_BITS),
      .SW           (SW)
   ) u_merge (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .ctl_i    (ctl0_ff),
      .lane_val (lane_val),
      .ctl_o    (ctl1),
      .sum_o    (sum)
   );

   mmed_divide #(
      .MAX_CHANNELS (MAX_CHANNELS),
      .SW           (SW),
      .NW           (NW)
   ) u_divide (
      .clock (clock),
      .reset (reset),
      .adv   (adv),
      .ctl_i (ctl1),
      .sum_i (sum),
      .n_eff (n_eff),
      .ctl_o (ctl3),
      .avg_o (avg)
   );

   // bucket update for the frame leaving the divider
   assign avg_w    = MW'(avg);
   assign count_in = count_ff + FPB_BITS'(1);
   assign min_in   = (avg_w < min_ff) ? avg_w : min_ff;
   assign max_in   = (avg_w > max_ff) ? avg_w : max_ff;
   assign emit     = (count_in >= limit) || ctl3.last;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         min_ff   <= POS_W;
         max_ff   <= NEG_W;
      end else if (take) begin
         if (emit) begin
            count_ff <= '0;
            min_ff   <= POS_W;
            max_ff   <= NEG_W;
         end else begin
            count_ff <= count_in;
            min_ff   <= min_in;
            max_ff   <= max_in;
         end
      end
   end

   // clamp to full scale for the result
   always_comb begin
      priority if (min_in < NEG_W) begin
         min_clamp = NEG_W;
      end else if (min_in > POS_W) begin
         min_clamp = POS_W;
      end else begin
         min_clamp = min_in;
      end
      priority if (max_in < NEG_W) begin
         max_clamp = NEG_W;
      end else if (max_in > POS_W) begin
         max_clamp = POS_W;
      end else begin
         max_clamp = max_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (take && emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take && emit) begin
         rsp_min_ff <= min_clamp[OUT_BITS-1:0];
         rsp_max_ff <= max_clamp[OUT_BITS-1:0];
         rsp_end_ff <= ctl3.last;
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.bucket_min = rsp_min_ff;
   assign rsp_chan.bucket_max = rsp_max_ff;
   assign rsp_chan.clip_end   = rsp_end_ff;
endmodule
